>>> rtl/rmq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared constants and codes for the reference-counted message queue.
// ----------------------------------------------------------------------------
package rmq_pkg;
	localparam int MAX_QUEUE_DEPTH = 12;
	localparam int EXTRA_BUFFERS   = 20;

	localparam logic [2:0] CMD_ALLOC   = 3'd0;
	localparam logic [2:0] CMD_RELEASE = 3'd1;
	localparam logic [2:0] CMD_WRITE   = 3'd2;
	localparam logic [2:0] CMD_READ    = 3'd3;
	localparam logic [2:0] CMD_IDXREAD = 3'd4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_EMPTY     = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_EXHAUSTED = 3'd3;
	localparam logic [2:0] ST_BAD       = 3'd4;

	localparam int OPT_NONBLOCK = 0;
	localparam int OPT_OVERRIDE = 1;
	localparam int OPT_PEEK     = 2;
	localparam int OPT_NEWEST   = 3;
endpackage
`default_nettype wire

>>> rtl/refcounted_message_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// refcounted_message_queue
// Pool of reference-counted buffers feeding a ring of buffer ids.
// ----------------------------------------------------------------------------
// done follows S_RD, S_EXEC, S_DONE for status-only commands; allocate adds S_ALLOCW
// each reference count change adds S_DROP and S_DROPW, S_SWAP and S_SWAPW on a swap;
//   peeks and indexed reads add S_RINGR and S_RINGW for the ring read
// take-newest and depth-change ring walks: S_RINGR, S_RINGW, S_DROP, S_DROPW per drop
// start is taken only while idle; busy drops with done; the receiver cannot stall
// reset: ring empty, write total and used count zero, no buffers created, depth 12
module refcounted_message_queue #(
	parameter int MAX_QUEUE_DEPTH = rmq_pkg::MAX_QUEUE_DEPTH,
	parameter int EXTRA_BUFFERS   = rmq_pkg::EXTRA_BUFFERS
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [2:0]  command,
	input  wire  [4:0]  buffer_id,
	input  wire  [3:0]  option_flags,
	input  wire  [31:0] reader_index,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [3:0]  cfg_data,
	output logic        done,
	output logic [2:0]  status,
	output logic [4:0]  result_buffer,
	output logic [31:0] next_reader_index
);
	localparam int RING_SLOTS = MAX_QUEUE_DEPTH + 1;
	localparam int POOL_SLOTS = MAX_QUEUE_DEPTH + EXTRA_BUFFERS;
	localparam int RW = $clog2(RING_SLOTS + 1);
	localparam int PW = $clog2(POOL_SLOTS + 1);
	localparam int IW = $clog2(POOL_SLOTS);

	// sequencer states
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_RD     = 4'd1;
	localparam logic [3:0] S_EXEC   = 4'd2;
	localparam logic [3:0] S_DROP   = 4'd3;
	localparam logic [3:0] S_DROPW  = 4'd4;
	localparam logic [3:0] S_SWAP   = 4'd5;
	localparam logic [3:0] S_SWAPW  = 4'd6;
	localparam logic [3:0] S_RINGR  = 4'd7;
	localparam logic [3:0] S_RINGW  = 4'd8;
	localparam logic [3:0] S_DONE   = 4'd9;
	localparam logic [3:0] S_ALLOCW = 4'd10;

	// memories
	logic [4:0]    ring_mem [RING_SLOTS];
	logic [7:0]    cnt_mem  [POOL_SLOTS];
	logic [4:0]    ord_mem  [POOL_SLOTS];
	logic [PW-1:0] pos_mem  [POOL_SLOTS];
	logic [POOL_SLOTS-1:0] pos_vld_q;

	logic [3:0]    state_q;
	logic [3:0]    depth_q;
	logic [RW-1:0] head_q, tail_q;
	logic [31:0]   total_q;
	logic [PW-1:0] used_q, created_q;

	logic [2:0]    cmd_q;
	logic [4:0]    id_q;
	logic [3:0]    opt_q;
	logic [31:0]   idx_q;
	logic [2:0]    st_q;
	logic [4:0]    res_q;
	logic          cfg_op_q;
	logic [3:0]    cfg_val_q;
	logic          walk_q;    // take-newest or depth-change walk active
	logic [4:0]    drop_id_q; // buffer whose reference count changes
	logic          after_q;   // continue in ring walk after drop
	logic          addref_q;

	// memory read ports with registered data
	logic [4:0]    ring_ra;
	logic [4:0]    ring_rd_q;
	logic [PW-1:0] cnt_ra;
	logic [7:0]    cnt_rd_q;
	logic [PW-1:0] ord_ra;
	logic [4:0]    ord_rd_q;
	logic [PW-1:0] pos_rd_q;

	// memory write ports
	logic          ring_we, cnt_we, ord_we, pos_we;
	logic [RW-1:0] ring_wa;
	logic [4:0]    ring_wd;
	logic [PW-1:0] cnt_wa, ord_wa, pos_wa;
	logic [7:0]    cnt_wd;
	logic [4:0]    ord_wd;
	logic [PW-1:0] pos_wd;

	logic [RW-1:0] edepth, len;
	logic [PW-1:0] mem_len;

	always_comb begin
		edepth = (depth_q == 4'd0) ? RW'(1) : RW'(depth_q);
		if (edepth > RW'(MAX_QUEUE_DEPTH))
			edepth = RW'(MAX_QUEUE_DEPTH);
		len = edepth + RW'(1);
		mem_len = PW'(edepth) + PW'(EXTRA_BUFFERS);
	end

	function automatic logic [RW-1:0] inc(input logic [RW-1:0] p, input logic [RW-1:0] l);
		inc = (p + RW'(1) == l) ? RW'(0) : p + RW'(1);
	endfunction

	function automatic logic [RW-1:0] dec(input logic [RW-1:0] p, input logic [RW-1:0] l);
		dec = (p == RW'(0)) ? l - RW'(1) : p - RW'(1);
	endfunction

	logic [RW-1:0] newest, cnt_ring, next_end;
	logic [RW:0]   cnt_wide;
	logic [31:0]   offset;
	logic          ring_empty, id_bad;
	always_comb begin
		newest = dec(tail_q, len);
		next_end = inc(tail_q, len);
		cnt_wide = {1'b0, tail_q} + {1'b0, len} - {1'b0, head_q};
		cnt_ring = (cnt_wide >= {1'b0, len}) ? RW'(cnt_wide - {1'b0, len}) : RW'(cnt_wide);
		offset = total_q - idx_q;
		ring_empty = head_q == tail_q;
		// ids at or past the created count were never allocated and hold no count
		id_bad = ((PW+1)'(id_q) >= (PW+1)'(POOL_SLOTS)) || (PW'(id_q) >= created_q)
			|| cnt_rd_q == 8'd0;
	end

	// indexed-read start position
	logic [RW-1:0] ix_start;
	logic [RW:0]   ix_wide;
	logic          ix_behind;
	always_comb begin
		ix_behind = offset > 32'(cnt_ring);
		ix_wide = {1'b0, tail_q} + {1'b0, len} - (RW+1)'(offset[RW-1:0]);
		ix_start = (ix_wide >= {1'b0, len}) ? RW'(ix_wide - {1'b0, len}) : RW'(ix_wide);
		if (ix_behind)
			ix_start = head_q;
	end

	assign busy = state_q != S_IDLE;
	assign cfg_ready = state_q == S_IDLE && !start;

	// memory arrays
	always_ff @(posedge clk) begin
		if (ring_we)
			ring_mem[ring_wa] <= ring_wd;
		ring_rd_q <= ring_mem[ring_ra[RW-1:0]];
		if (cnt_we)
			cnt_mem[cnt_wa[IW-1:0]] <= cnt_wd;
		cnt_rd_q <= cnt_mem[cnt_ra[IW-1:0]];
		if (ord_we)
			ord_mem[ord_wa[IW-1:0]] <= ord_wd;
		ord_rd_q <= ord_mem[ord_ra[IW-1:0]];
		if (pos_we)
			pos_mem[pos_wa[IW-1:0]] <= pos_wd;
		pos_rd_q <= pos_mem[cnt_ra[IW-1:0]];
	end

	logic [3:0]    state_d;
	logic [RW-1:0] head_d, tail_d;
	logic [31:0]   total_d, idx_d;
	logic [PW-1:0] used_d, created_d;
	logic [2:0]    st_d;
	logic [4:0]    res_d, drop_d;
	logic          walk_d, after_d, addref_d;
	logic [POOL_SLOTS-1:0] vld_d;
	logic [3:0]    depth_d;

	// control sequencer
	always_comb begin
		state_d = state_q; head_d = head_q; tail_d = tail_q; total_d = total_q;
		idx_d = idx_q; used_d = used_q; created_d = created_q; st_d = st_q;
		res_d = res_q; drop_d = drop_id_q; walk_d = walk_q; after_d = after_q;
		addref_d = addref_q; vld_d = pos_vld_q; depth_d = depth_q;
		ring_ra = 5'(head_q); cnt_ra = PW'(id_q); ord_ra = PW'(used_q);
		ring_we = 1'b0; ring_wa = tail_q; ring_wd = id_q;
		cnt_we = 1'b0; cnt_wa = PW'(id_q); cnt_wd = 8'd0;
		ord_we = 1'b0; ord_wa = PW'(used_q); ord_wd = 5'd0;
		pos_we = 1'b0; pos_wa = PW'(id_q); pos_wd = used_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_RD;
				end else if (cfg_valid) begin
					walk_d = 1'b1;
					state_d = S_RINGR;
				end
			end
			S_RD: begin
				// read ports settle: cnt(id), ord(used), ring(head)
				state_d = S_EXEC;
			end
			S_EXEC: begin
				st_d = rmq_pkg::ST_OK; res_d = 5'd0; after_d = 1'b0; addref_d = 1'b0;
				state_d = S_DONE;
				unique case (cmd_q)
					rmq_pkg::CMD_ALLOC: begin
						if (created_q > used_q) begin
							res_d = ord_rd_q;
						end else if (created_q >= mem_len) begin
							st_d = rmq_pkg::ST_EXHAUSTED;
						end else begin
							res_d = 5'(created_q);
							ord_we = 1'b1; ord_wa = created_q; ord_wd = 5'(created_q);
							created_d = created_q + PW'(1);
						end
						if (st_d == rmq_pkg::ST_OK) begin
							state_d = S_ALLOCW;
						end
					end
					rmq_pkg::CMD_RELEASE: begin
						if (id_bad) st_d = rmq_pkg::ST_BAD;
						else begin
							drop_d = id_q; state_d = S_DROP;
						end
					end
					rmq_pkg::CMD_WRITE: begin
						if (id_bad) st_d = rmq_pkg::ST_BAD;
						else if (next_end == head_q && (opt_q[rmq_pkg::OPT_NONBLOCK]
							|| !opt_q[rmq_pkg::OPT_OVERRIDE]))
							st_d = rmq_pkg::ST_FULL;
						else begin
							ring_we = 1'b1;
							total_d = total_q + 32'd1;
							tail_d = next_end;
							if (next_end == head_q) begin
								drop_d = ring_rd_q; head_d = inc(head_q, len);
								state_d = S_DROP;
							end
						end
					end
					rmq_pkg::CMD_READ: begin
						if (ring_empty) st_d = rmq_pkg::ST_EMPTY;
						else if (opt_q[rmq_pkg::OPT_PEEK]) begin
							addref_d = 1'b1;
							state_d = S_RINGR;
						end else if (opt_q[rmq_pkg::OPT_NEWEST]) begin
							walk_d = 1'b1; state_d = S_RINGR;
						end else begin
							res_d = ring_rd_q; head_d = inc(head_q, len);
						end
					end
					rmq_pkg::CMD_IDXREAD: begin
						if (ring_empty || total_q <= idx_q) st_d = rmq_pkg::ST_EMPTY;
						else begin
							if (ix_behind) idx_d = total_q - 32'(cnt_ring);
							if (opt_q[rmq_pkg::OPT_PEEK]) begin
								if (!opt_q[rmq_pkg::OPT_NEWEST]) after_d = 1'b1;
							end else if (opt_q[rmq_pkg::OPT_NEWEST])
								idx_d = total_q;
							else begin
								after_d = 1'b1;
								idx_d = (ix_behind ? total_q - 32'(cnt_ring) : idx_q) + 32'd1;
							end
							res_d = 5'(ix_start);
							addref_d = 1'b1; state_d = S_RINGR;
						end
					end
					default: ;
				endcase
			end
			S_ALLOCW: begin
				cnt_we = 1'b1; cnt_wa = PW'(res_q); cnt_wd = 8'd1;
				pos_we = 1'b1; pos_wa = PW'(res_q); pos_wd = used_q;
				vld_d[res_q] = 1'b1;
				used_d = used_q + PW'(1);
				state_d = S_DONE;
			end
			S_RINGR: begin
				// pick the ring slot to read
				if (cfg_op_q) begin
					ring_ra = 5'(head_q);
				end else if (cmd_q == rmq_pkg::CMD_IDXREAD) begin
					ring_ra = (opt_q[rmq_pkg::OPT_NEWEST] && !after_d) ?
						5'(newest) : res_q;
				end else if (walk_q) begin
					ring_ra = 5'(head_q);
				end else begin
					ring_ra = opt_q[rmq_pkg::OPT_NEWEST] ? 5'(newest) : 5'(head_q);
				end
				state_d = S_RINGW;
				if (cfg_op_q && (head_q == tail_q || head_q >= len)) begin
					head_d = '0; tail_d = '0; depth_d = cfg_val_q;
					walk_d = 1'b0; state_d = S_DONE;
				end
			end
			S_RINGW: begin
				cnt_ra = PW'(ring_rd_q);
				if (addref_q) begin
					res_d = ring_rd_q; drop_d = ring_rd_q;
					state_d = S_DROP;
				end else begin
					// walk: drop the head entry; a read walk stops at the newest
					head_d = inc(head_q, len);
					if (!cfg_op_q && inc(head_q, len) == tail_q) begin
						res_d = ring_rd_q; walk_d = 1'b0; state_d = S_DONE;
					end else begin
						drop_d = ring_rd_q; after_d = 1'b1; state_d = S_DROP;
					end
				end
			end
			S_DROP: begin
				// count and position of drop_id read
				cnt_ra = PW'(drop_id_q);
				ord_ra = used_q - PW'(1);
				state_d = S_DROPW;
			end
			S_DROPW: begin
				cnt_ra = PW'(drop_id_q);
				ord_ra = used_q - PW'(1);
				state_d = S_DONE;
				if ((PW+1)'(drop_id_q) < (PW+1)'(POOL_SLOTS)) begin
					if (addref_q) begin
						if (cnt_rd_q != 8'd255) begin
							cnt_we = 1'b1; cnt_wa = PW'(drop_id_q); cnt_wd = cnt_rd_q + 8'd1;
						end
					end else if (cnt_rd_q != 8'd0) begin
						cnt_we = 1'b1; cnt_wa = PW'(drop_id_q); cnt_wd = cnt_rd_q - 8'd1;
						if (cnt_rd_q == 8'd1 && pos_vld_q[drop_id_q] && used_q != '0) begin
							vld_d[drop_id_q] = 1'b0;
							used_d = used_q - PW'(1);
							if (pos_rd_q != used_q - PW'(1)) state_d = S_SWAP;
						end
					end
				end
				if (state_d == S_DONE && walk_q) state_d = S_RINGR;
			end
			S_SWAP: begin
				// ord_rd_q holds the last used buffer, pos_rd_q the freed slot
				ord_we = 1'b1; ord_wa = pos_rd_q; ord_wd = ord_rd_q;
				pos_we = 1'b1; pos_wa = PW'(ord_rd_q); pos_wd = pos_rd_q;
				state_d = S_SWAPW;
			end
			S_SWAPW: begin
				ord_we = 1'b1; ord_wa = used_q; ord_wd = drop_id_q;
				state_d = walk_q ? S_RINGR : S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; depth_q <= 4'(MAX_QUEUE_DEPTH < 12 ? MAX_QUEUE_DEPTH : 12);
			head_q <= '0; tail_q <= '0; total_q <= '0; used_q <= '0; created_q <= '0;
			pos_vld_q <= '0; walk_q <= 1'b0; cfg_op_q <= 1'b0; done <= 1'b0;
		end else begin
			state_q <= state_d; head_q <= head_d; tail_q <= tail_d; total_q <= total_d;
			used_q <= used_d; created_q <= created_d; pos_vld_q <= vld_d;
			walk_q <= walk_d; depth_q <= depth_d;
			done <= state_q == S_DONE && !cfg_op_q;
			if (state_q == S_IDLE)
				cfg_op_q <= !start && cfg_valid;
		end
	end

	// command and result payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			cmd_q <= command; id_q <= buffer_id; opt_q <= option_flags;
			idx_q <= reader_index; cfg_val_q <= cfg_data; addref_q <= 1'b0;
		end else begin
			idx_q <= idx_d; addref_q <= addref_d;
		end
		st_q <= st_d; res_q <= res_d; drop_id_q <= drop_d; after_q <= after_d;
		if (state_q == S_DONE) begin
			status <= st_q;
			result_buffer <= (st_q == rmq_pkg::ST_OK && (cmd_q == rmq_pkg::CMD_ALLOC ||
				cmd_q == rmq_pkg::CMD_READ || cmd_q == rmq_pkg::CMD_IDXREAD)) ? res_q : 5'd0;
			next_reader_index <= idx_q;
		end
	end
endmodule
`default_nettype wire

>>> rtl/rmq_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_checker
// Port-level checks for the message queue.
// ----------------------------------------------------------------------------
module rmq_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        start,
	input wire        busy,
	input wire        done,
	input wire        cfg_ready,
	input wire [2:0]  status,
	input wire [4:0]  result_buffer
);
	// accepted command raises busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised");
	// done only follows a busy period
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("done without command");
	// a failed command returns no buffer
	a_res: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != rmq_pkg::ST_OK |-> result_buffer == 5'd0)
		else $error("result on error");
	// no config beats while busy
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cfg_ready) else $error("cfg ready while busy");
endmodule

bind refcounted_message_queue rmq_checker u_rmq_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.cfg_ready(cfg_ready), .status(status), .result_buffer(result_buffer)
);
`default_nettype wire
